[sv/des_block_cipher_assert.svh]
// Assertion macros for the DES block cipher RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef DES_BLOCK_CIPHER_ASSERT_SVH
`define DES_BLOCK_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
`define DES_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DES_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define DES_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

[sv/des_pkg.sv]
// Package for the DES block cipher: permutation tables, S-boxes and helpers.
// No dependencies; used by des_round_cell and des_block_cipher.
package des_pkg;

   localparam int NumRounds = 16;
   localparam logic OpEncrypt = 1'b0;
   localparam logic OpDecrypt = 1'b1;

   typedef logic [7:0] tab_entry_type;

   typedef struct packed {
      logic        valid;
      logic        decrypt;
      logic [27:0] c;
      logic [27:0] d;
      logic [31:0] l;
      logic [31:0] r;
   } cell_data_type;

   localparam tab_entry_type TAB_IP [64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
   localparam tab_entry_type TAB_FP [64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
   localparam tab_entry_type TAB_E [48] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
   localparam tab_entry_type TAB_P [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
   localparam tab_entry_type TAB_PC1 [56] = '{
      57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
      10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
   localparam tab_entry_type TAB_PC2 [48] = '{
      14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
   localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

   localparam logic [3:0] TAB_S [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   // Initial permutation
   function automatic logic [63:0] perm_ip(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_IP[i]];
      return r;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] v);
      logic [63:0] r;
      for (int i = 0; i < 64; i++) r[63-i] = v[64-TAB_FP[i]];
      return r;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] v);
      logic [55:0] r;
      for (int i = 0; i < 56; i++) r[55-i] = v[64-TAB_PC1[i]];
      return r;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] v);
      logic [47:0] r;
      for (int i = 0; i < 48; i++) r[47-i] = v[56-TAB_PC2[i]];
      return r;
   endfunction

   function automatic logic [47:0] perm_e(input logic [31:0] v);
      logic [47:0] r;
      for (int i = 0; i < 48; i++) r[47-i] = v[32-TAB_E[i]];
      return r;
   endfunction

   function automatic logic [31:0] perm_p(input logic [31:0] v);
      logic [31:0] r;
      for (int i = 0; i < 32; i++) r[31-i] = v[32-TAB_P[i]];
      return r;
   endfunction

   // Round function: expand, mix key, S-box, P
   function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] e;
      logic [31:0] o;
      logic [5:0]  six;
      e = perm_e(r) ^ k;
      for (int s = 0; s < 8; s++) begin
         six = e[47-6*s -: 6];
         o[31-4*s -: 4] = TAB_S[s][{six[5], six[0], six[4:1]}];
      end
      return perm_p(o);
   endfunction

endpackage

[sv/des_block_cipher.sv]
// Top level of the DES ECB block cipher: key register, input and output stages.
// Depends on des_pkg and des_round_cell (sixteen round cells in a chain).
//
// Usage:
//   Write the 64-bit key with csr_we/csr_wdata while no transfer is in flight.
//   Present a block on req_block_in and req_opcode (0 encrypt, 1 decrypt) and
//   raise start; busy is never high, so every start cycle is a transfer.
//   A new block may be started every cycle: throughput is one block per clock.
//   The block passes through 18 register stages before rsp_valid rises: one input
//   stage (initial permutation, PC-1 of the key), sixteen round cells and one
//   output stage (final permutation).
//   The result shows on rsp_block_out for exactly one cycle with rsp_valid
//   high; the receiver takes it then, it cannot stall the block.
//   Reset clears the key to zero and drops every block in flight.
//   Blocks carry their own copy of the key schedule down the chain, so a key
//   change affects only blocks started after it.
`include "des_block_cipher_assert.svh"
module des_block_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [63:0] req_block_in,
   output logic        rsp_valid,
   output logic [63:0] rsp_block_out
);

   logic [63:0] key_ff;
   des_pkg::cell_data_type head_ff, head_in;
   des_pkg::cell_data_type chain [des_pkg::NumRounds+1];
   logic        out_valid_ff;
   logic [63:0] out_block_ff;
   logic [63:0] ip_blk;
   logic [55:0] cd;

   // Hold the key; reset clears it
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_we) begin
         key_ff <= csr_wdata;
      end
   end

   assign busy = 1'b0;

   // Input stage: permute block and key
   always_comb begin
      ip_blk = des_pkg::perm_ip(req_block_in);
      cd     = des_pkg::perm_pc1(key_ff);
      head_in.valid   = start;
      head_in.decrypt = (req_opcode == des_pkg::OpDecrypt);
      head_in.c = cd[55:28];
      head_in.d = cd[27:0];
      head_in.l = ip_blk[63:32];
      head_in.r = ip_blk[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else begin
         head_ff.valid <= head_in.valid;
      end
      head_ff.decrypt <= head_in.decrypt;
      head_ff.c <= head_in.c;
      head_ff.d <= head_in.d;
      head_ff.l <= head_in.l;
      head_ff.r <= head_in.r;
   end

   assign chain[0] = head_ff;

   // Advance each block one round per cycle
   for (genvar g = 0; g < des_pkg::NumRounds; g++) begin : g_round
      des_round_cell #(.RoundIdx(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   // Output stage: swap halves, final permutation
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= chain[des_pkg::NumRounds].valid;
      end
      out_block_ff <= des_pkg::perm_fp({chain[des_pkg::NumRounds].r,
                                        chain[des_pkg::NumRounds].l});
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_block_out = out_block_ff;

   `DES_ASSERT_NEXT(a_start_enters, clock, reset, start, chain[0].valid, "start not captured")
   `DES_ASSERT_NEXT(a_tail_leaves, clock, reset, chain[des_pkg::NumRounds].valid, rsp_valid, "result dropped")
   `DES_ASSERT_NEXT(a_no_ghost, clock, reset, !chain[des_pkg::NumRounds].valid, !rsp_valid, "result invented")

endmodule

[sv/des_round_cell.sv]
// One DES round cell: key-half rotation plus one Feistel round, registered.
// Depends on des_pkg; instanced 16 times by des_block_cipher.
`include "des_block_cipher_assert.svh"
module des_round_cell #(
   parameter int RoundIdx = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  des_pkg::cell_data_type cell_in,
   output des_pkg::cell_data_type cell_out
);

   localparam logic [1:0] Rot = des_pkg::TAB_ROT[RoundIdx];
   // Decrypt walks the schedule backward: rotate right by the amount of
   // the later round, applied after the key of this round is taken.
   localparam logic [1:0] RotDec = des_pkg::TAB_ROT[des_pkg::NumRounds - 1 - RoundIdx];

   des_pkg::cell_data_type cell_ff, cell_in_d;
   logic [27:0] c_enc, d_enc, c_key, d_key, c_next, d_next;
   logic [47:0] sub_key;

   function automatic logic [27:0] rotl(input logic [27:0] h, input logic [1:0] s);
      return (s == 2'd2) ? {h[25:0], h[27:26]} : {h[26:0], h[27]};
   endfunction
   function automatic logic [27:0] rotr(input logic [27:0] h, input logic [1:0] s);
      return (s == 2'd2) ? {h[1:0], h[27:2]} : {h[0], h[27:1]};
   endfunction

   always_comb begin
      c_enc = rotl(cell_in.c, Rot);
      d_enc = rotl(cell_in.d, Rot);
      // Decrypt: first key is the PC-1 value itself (full rotation of 28)
      c_key = cell_in.decrypt ? cell_in.c : c_enc;
      d_key = cell_in.decrypt ? cell_in.d : d_enc;
      c_next = cell_in.decrypt ? rotr(cell_in.c, RotDec) : c_enc;
      d_next = cell_in.decrypt ? rotr(cell_in.d, RotDec) : d_enc;
      sub_key = des_pkg::perm_pc2({c_key, d_key});
      cell_in_d.valid   = cell_in.valid;
      cell_in_d.decrypt = cell_in.decrypt;
      cell_in_d.c = c_next;
      cell_in_d.d = d_next;
      cell_in_d.l = cell_in.r;
      cell_in_d.r = cell_in.l ^ des_pkg::feistel(cell_in.r, sub_key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in_d.valid;
      end
      cell_ff.decrypt <= cell_in_d.decrypt;
      cell_ff.c <= cell_in_d.c;
      cell_ff.d <= cell_in_d.d;
      cell_ff.l <= cell_in_d.l;
      cell_ff.r <= cell_in_d.r;
   end

   assign cell_out = cell_ff;

   `DES_ASSERT_NEXT(a_valid_moves, clock, reset, cell_in.valid, cell_out.valid, "valid lost in cell")
   `DES_ASSERT_NEXT(a_l_from_r, clock, reset, cell_in.valid, cell_out.l == $past(cell_in.r), "L not handed from R")
   `DES_ASSERT_NEXT(a_idle_moves, clock, reset, !cell_in.valid, !cell_out.valid, "valid invented in cell")

endmodule
